/* sv/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Concurrent assertion helpers.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`endif

/* sv/pmts_pkg.sv */
package pmts_pkg;
    localparam int MAX_TIMERS = 16;
    localparam int BUCKETS_PER_UNIT = 100;
    localparam int IDX_W = $clog2(MAX_TIMERS);
    localparam int CNT_W = $clog2(MAX_TIMERS + 1);
    localparam int BKT_W = $clog2(4 * BUCKETS_PER_UNIT);
    localparam int STEP_RAW = 1000 / BUCKETS_PER_UNIT;
    localparam int STEP = (STEP_RAW == 0) ? 1 : STEP_RAW;
    localparam int STEP_SHIFT = 20;
    localparam logic [31:0] STEP_MUL = 32'(((1 << STEP_SHIFT) + STEP - 1) / STEP);
    localparam logic [31:0] DIGIT_BASE = 32'd1000;
    localparam int DIV_SHIFT = 38;
    localparam logic [63:0] DIV_MUL =
        ((64'd1 << DIV_SHIFT) + 64'(DIGIT_BASE) - 64'd1) / 64'(DIGIT_BASE);
    localparam int QD_DEPTH = 2;

    localparam logic [1:0] CMD_REG = 2'd0;
    localparam logic [1:0] CMD_UNREG = 2'd1;
    localparam logic [1:0] CMD_TICK = 2'd2;
    localparam logic [1:0] KIND_STATUS = 2'd0;
    localparam logic [1:0] KIND_FIRED = 2'd1;
    localparam logic [1:0] KIND_SLEEP = 2'd2;

    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] handle;
        logic [31:0] elapse;
        logic [1:0]  unit;
        logic [63:0] now;
    } t_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] fired_handle;
        logic        accepted;
        logic [63:0] wait_ns;
        logic        last;
    } t_result;
endpackage

/* sv/periodic_multi_timer_scheduler.sv */
// Periodic timer table, 16 entries.
// Input channel i_valid/o_ready carries command, handle, elapse, unit, now.
// Output channel o_valid/i_ready carries kind, fired_handle, accepted,
// wait_ns, last; last marks the final beat of an input item.
// A two-entry queue takes items while the back end works on one item.
// Register path: the elapse is split into decimal digits, each split passing
// S_DIG and S_DIV (seconds need no split), then bucket, multiply and table
// write; a rejected register or an unknown command goes straight to the
// status beat. Unregister: one entry per cycle scan, then the table update.
// Tick: each selection of a fired timer scans the table one entry a cycle;
// once none is left, deadlines are reloaded and a scan for the earliest
// deadline comes before the sleep beat.
// One item is worked at a time.
// Synchronous active-low reset empties the table and the queue.
// A stalled receiver holds the output beat; the back end waits at the next
// beat and the queue fills, then o_ready drops.
`include "assert_macros.svh"
module periodic_multi_timer_scheduler (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_command,
    input  logic [15:0] i_handle,
    input  logic [31:0] i_elapse,
    input  logic [1:0]  i_unit,
    input  logic [63:0] i_now,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_kind,
    output logic [15:0] o_fired_handle,
    output logic        o_accepted,
    output logic [63:0] o_wait_ns,
    output logic        o_last
);
    import pmts_pkg::*;

    t_item   w_in, w_q;
    t_result w_res;
    logic    w_qv, w_qr;

    assign w_in = '{command: i_command, handle: i_handle, elapse: i_elapse,
                    unit: i_unit, now: i_now};

    pmts_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_item(w_in), .o_valid(w_qv), .i_ready(w_qr), .o_item(w_q)
    );

    pmts_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(w_qv), .o_ready(w_qr),
        .i_item(w_q), .o_valid(o_valid), .i_ready(i_ready), .o_res(w_res)
    );

    assign o_kind = w_res.kind;
    assign o_fired_handle = w_res.fired_handle;
    assign o_accepted = w_res.accepted;
    assign o_wait_ns = w_res.wait_ns;
    assign o_last = w_res.last;

    `ASSERT_NEVER(a_fired_last, i_clk, i_rst_n, o_valid && o_kind == KIND_FIRED && o_last,
        "fired beat marked last")
    `ASSERT_NEVER(a_status_last, i_clk, i_rst_n,
        o_valid && o_kind != KIND_FIRED && !o_last, "closing beat without last")
    `ASSERT_CLK(a_hold, i_clk, i_rst_n, o_valid && !i_ready |=> o_valid && $stable(w_res),
        "output beat changed under stall")
endmodule

/* sv/pmts_front.sv */
module pmts_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  pmts_pkg::t_item i_item,
    output logic            o_valid,
    input  logic            i_ready,
    output pmts_pkg::t_item o_item
);
    import pmts_pkg::*;

    t_item                r_q [QD_DEPTH];
    logic [$clog2(QD_DEPTH)-1:0] r_wp, r_rp;
    logic [$clog2(QD_DEPTH+1)-1:0] r_cnt;
    logic                 w_push, w_pop;

    assign o_ready = (r_cnt != QD_DEPTH[$clog2(QD_DEPTH+1)-1:0]);
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_q[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_q[r_wp] <= i_item;
                r_wp <= r_wp + 1'b1;
            end
            if (w_pop) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + {{($clog2(QD_DEPTH+1)-1){1'b0}}, w_push}
                           - {{($clog2(QD_DEPTH+1)-1){1'b0}}, w_pop};
        end
    end
endmodule

/* sv/pmts_back.sv */
module pmts_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  pmts_pkg::t_item   i_item,
    output logic              o_valid,
    input  logic              i_ready,
    output pmts_pkg::t_result o_res
);
    import pmts_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_DIG, S_DIV, S_BKT, S_MUL, S_REGW, S_UNREG, S_SCAN, S_EMIT, S_RELOAD,
        S_MIN, S_SLEEP, S_OUT
    } t_state;

    t_state              r_st;
    t_item               r_it;
    logic [MAX_TIMERS-1:0] r_val, r_due, r_done;
    logic [15:0]         r_hdl [MAX_TIMERS];
    logic [62:0]         r_per [MAX_TIMERS];
    logic [63:0]         r_dl  [MAX_TIMERS];
    logic [BKT_W-1:0]    r_bkt [MAX_TIMERS];
    logic [IDX_W-1:0]    r_age [MAX_TIMERS];
    logic [IDX_W-1:0]    r_i, r_sel;
    logic                r_found;
    logic [31:0]         r_rem;
    logic [31:0]         r_quo;
    logic [9:0]          r_dig [4];
    logic [1:0]          r_d;
    logic [BKT_W-1:0]    r_nb;
    logic [62:0]         r_np;
    logic [63:0]         r_best;
    logic                r_any;
    logic                r_acc;
    t_result             r_res;
    logic                r_ov;

    logic [IDX_W-1:0]    w_free;
    logic                w_hasfree;
    logic [29:0]         w_scale;
    logic                w_before;
    logic [1:0]          w_tu;
    logic [9:0]          w_q;
    logic [31:0]         w_qp;
    logic [63:0]         w_prod;
    logic                w_emit;

    always_comb begin
        w_free = '0;
        w_hasfree = 1'b0;
        for (int k = MAX_TIMERS - 1; k >= 0; k--) begin
            if (!r_val[k]) begin
                w_free = IDX_W'(k);
                w_hasfree = 1'b1;
            end
        end
    end

    always_comb begin
        case (r_it.unit)
            2'd0: w_scale = 30'd1;
            2'd1: w_scale = 30'd1000;
            2'd2: w_scale = 30'd1000000;
            default: w_scale = 30'd1000000000;
        endcase
    end

    always_comb begin
        if (r_dig[3] != '0) w_tu = 2'd3;
        else if (r_dig[2] != '0) w_tu = 2'd2;
        else if (r_dig[1] != '0) w_tu = 2'd1;
        else w_tu = 2'd0;
        w_qp = {22'd0, r_dig[w_tu]} * STEP_MUL;
        w_q = 10'(w_qp >> STEP_SHIFT);
        if (w_q > 10'(BUCKETS_PER_UNIT - 1)) w_q = 10'(BUCKETS_PER_UNIT - 1);
    end

    always_comb begin
        if (r_bkt[r_i] != r_bkt[r_sel]) w_before = r_bkt[r_i] < r_bkt[r_sel];
        else if (r_dl[r_i] != r_dl[r_sel]) w_before = r_dl[r_i] < r_dl[r_sel];
        else w_before = r_age[r_i] < r_age[r_sel];
    end

    assign w_prod  = {32'd0, r_rem} * DIV_MUL;
    assign w_emit  = ((r_st == S_EMIT && r_found) || r_st == S_SLEEP || r_st == S_OUT)
                     && (!r_ov || i_ready);
    assign o_ready = (r_st == S_IDLE);
    assign o_valid = r_ov;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_val <= '0;
            r_ov <= 1'b0;
        end else begin
            r_ov <= w_emit || (r_ov && !i_ready);
            case (r_st)
                S_IDLE: if (i_valid) begin
                    r_it <= i_item;
                    r_i <= '0;
                    r_found <= 1'b0;
                    r_acc <= 1'b0;
                    case (i_item.command)
                        CMD_REG: begin
                            if (i_item.elapse == '0 || !w_hasfree) r_st <= S_OUT;
                            else begin
                                r_rem <= i_item.elapse;
                                r_d <= i_item.unit;
                                r_dig[0] <= '0; r_dig[1] <= '0;
                                r_dig[2] <= '0; r_dig[3] <= '0;
                                r_st <= S_DIG;
                            end
                        end
                        CMD_UNREG: r_st <= S_UNREG;
                        CMD_TICK: begin
                            r_done <= '0;
                            for (int k = 0; k < MAX_TIMERS; k++)
                                r_due[k] <= r_val[k] && (r_dl[k] <= i_item.now);
                            r_st <= S_SCAN;
                        end
                        default: r_st <= S_OUT;
                    endcase
                end
                S_DIG: begin
                    if (r_d == 2'd3) begin
                        r_dig[3] <= r_rem > 32'd1023 ? 10'd1023 : r_rem[9:0];
                        r_st <= S_BKT;
                    end else begin
                        r_quo <= 32'(w_prod >> DIV_SHIFT);
                        r_st <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_dig[r_d] <= 10'(r_rem - r_quo * DIGIT_BASE);
                    r_rem <= r_quo;
                    r_d <= r_d + 2'd1;
                    r_st <= S_DIG;
                end
                S_BKT: begin
                    r_nb <= BKT_W'(w_tu * BUCKETS_PER_UNIT) + BKT_W'(w_q);
                    r_st <= S_MUL;
                end
                S_MUL: begin
                    r_np <= 63'({31'd0, r_it.elapse} * {33'd0, w_scale});
                    r_st <= S_REGW;
                end
                S_REGW: begin
                    for (int k = 0; k < MAX_TIMERS; k++)
                        if (r_val[k]) r_age[k] <= r_age[k] + 1'b1;
                    r_val[w_free] <= 1'b1;
                    r_hdl[w_free] <= r_it.handle;
                    r_per[w_free] <= r_np;
                    r_dl[w_free] <= r_it.now + {1'b0, r_np};
                    r_bkt[w_free] <= r_nb;
                    r_age[w_free] <= '0;
                    r_acc <= 1'b1;
                    r_st <= S_OUT;
                end
                S_UNREG: begin
                    if (r_val[r_i] && r_hdl[r_i] == r_it.handle &&
                        (!r_found || r_age[r_i] > r_age[r_sel])) begin
                        r_sel <= r_i;
                        r_found <= 1'b1;
                    end
                    if (r_i == IDX_W'(MAX_TIMERS - 1)) begin
                        r_i <= '0;
                        r_st <= S_RELOAD;
                    end else r_i <= r_i + 1'b1;
                end
                S_RELOAD: begin
                    if (r_found) begin
                        r_val[r_sel] <= 1'b0;
                        for (int k = 0; k < MAX_TIMERS; k++)
                            if (r_val[k] && r_age[k] > r_age[r_sel])
                                r_age[k] <= r_age[k] - 1'b1;
                        r_acc <= 1'b1;
                    end
                    r_st <= S_OUT;
                end
                S_SCAN: begin
                    if (r_due[r_i] && !r_done[r_i] && (!r_found || w_before)) begin
                        r_sel <= r_i;
                        r_found <= 1'b1;
                    end
                    if (r_i == IDX_W'(MAX_TIMERS - 1)) begin
                        r_i <= '0;
                        r_st <= S_EMIT;
                    end else r_i <= r_i + 1'b1;
                end
                S_EMIT: if (!r_ov || i_ready) begin
                    if (r_found) begin
                        r_done[r_sel] <= 1'b1;
                        r_res <= '{kind: KIND_FIRED, fired_handle: r_hdl[r_sel],
                                   accepted: 1'b0, wait_ns: '0, last: 1'b0};
                        r_found <= 1'b0;
                        r_st <= S_SCAN;
                    end else begin
                        for (int k = 0; k < MAX_TIMERS; k++)
                            if (r_done[k]) r_dl[k] <= r_it.now + {1'b0, r_per[k]};
                        r_any <= 1'b0;
                        r_st <= S_MIN;
                    end
                end
                S_MIN: begin
                    if (r_val[r_i] && (!r_any || r_dl[r_i] < r_best)) begin
                        r_best <= r_dl[r_i];
                        r_any <= 1'b1;
                    end
                    if (r_i == IDX_W'(MAX_TIMERS - 1)) r_st <= S_SLEEP;
                    else r_i <= r_i + 1'b1;
                end
                S_SLEEP: if (!r_ov || i_ready) begin
                    r_res <= '{kind: KIND_SLEEP, fired_handle: '0, accepted: 1'b0,
                               wait_ns: r_any ? r_best - r_it.now : '1, last: 1'b1};
                    r_st <= S_IDLE;
                end
                S_OUT: if (!r_ov || i_ready) begin
                    r_res <= '{kind: KIND_STATUS, fired_handle: '0, accepted: r_acc,
                               wait_ns: '0, last: 1'b1};
                    r_st <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule

/* sim/periodic_multi_timer_scheduler_tb.sv */
`timescale 1ns / 100ps
module periodic_multi_timer_scheduler_tb;
    import pmts_pkg::*;

    localparam int SLOTS = 16;
    localparam int NBKT = 100;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam logic [1:0] CMD_BAD = 2'd3;
    localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [1:0]  i_command;
    logic [15:0] i_handle;
    logic [31:0] i_elapse;
    logic [1:0]  i_unit;
    logic [63:0] i_now;
    logic        o_valid;
    logic        i_ready;
    logic [1:0]  o_kind;
    logic [15:0] o_fired_handle;
    logic        o_accepted;
    logic [63:0] o_wait_ns;
    logic        o_last;

    periodic_multi_timer_scheduler dut (.*);

    // timer table kept by the testbench
    logic        tbl_valid    [SLOTS];
    logic [15:0] tbl_handle   [SLOTS];
    logic [63:0] tbl_period   [SLOTS];
    logic [63:0] tbl_deadline [SLOTS];
    int unsigned tbl_bucket   [SLOTS];
    int unsigned tbl_age      [SLOTS];

    t_result     pending_beats[$];
    int          fail_count;
    int          idle_cycles;
    logic [63:0] clock_ns;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    function automatic int unsigned bucket_of(input logic [31:0] el, input logic [1:0] u);
        logic [31:0] dig [4];
        int unsigned tu;
        int unsigned q;
        for (int k = 0; k < 4; k++) dig[k] = '0;
        case (u)
            2'd3: dig[3] = el;
            2'd2: begin
                dig[3] = el / 1000; dig[2] = el % 1000;
            end
            2'd1: begin
                dig[3] = el / 1000000; dig[2] = (el % 1000000) / 1000; dig[1] = el % 1000;
            end
            default: begin
                dig[3] = el / 1000000000; dig[2] = (el % 1000000000) / 1000000;
                dig[1] = (el % 1000000) / 1000; dig[0] = el % 1000;
            end
        endcase
        if (dig[3] != 0) tu = 3;
        else if (dig[2] != 0) tu = 2;
        else if (dig[1] != 0) tu = 1;
        else tu = 0;
        q = dig[tu] / (1000 / NBKT);
        if (q > NBKT - 1) q = NBKT - 1;
        return tu * NBKT + q;
    endfunction

    function automatic bit fires_first(input int a, input int b);
        if (tbl_bucket[a] != tbl_bucket[b]) return tbl_bucket[a] < tbl_bucket[b];
        if (tbl_deadline[a] != tbl_deadline[b]) return tbl_deadline[a] < tbl_deadline[b];
        return tbl_age[a] < tbl_age[b];
    endfunction

    function automatic void queue_beat(input logic [1:0] kind, input logic [15:0] h,
                                       input logic acc, input logic [63:0] wt,
                                       input logic last);
        t_result r;
        r.kind = kind; r.fired_handle = h; r.accepted = acc; r.wait_ns = wt; r.last = last;
        pending_beats.insert(pending_beats.size(), r);
    endfunction

    function automatic void predict_scheduler(input logic [1:0] cmd, input logic [15:0] h,
                                              input logic [31:0] el, input logic [1:0] u,
                                              input logic [63:0] now);
        int slot;
        int due [$];
        int j;
        bit any;
        logic [63:0] best;
        logic [63:0] scale;
        slot = -1;
        any = 1'b0;
        best = '0;
        case (cmd)
            CMD_REG: begin
                if (el != 0)
                    for (int i = SLOTS - 1; i >= 0; i--) if (!tbl_valid[i]) slot = i;
                if (slot < 0) begin
                    queue_beat(KIND_STATUS, '0, 1'b0, '0, 1'b1);
                    return;
                end
                for (int i = 0; i < SLOTS; i++) if (tbl_valid[i]) tbl_age[i]++;
                case (u)
                    2'd0: scale = 64'd1;
                    2'd1: scale = 64'd1000;
                    2'd2: scale = 64'd1000000;
                    default: scale = 64'd1000000000;
                endcase
                tbl_valid[slot] = 1'b1;
                tbl_handle[slot] = h;
                tbl_period[slot] = {32'd0, el} * scale;
                tbl_deadline[slot] = now + tbl_period[slot];
                tbl_bucket[slot] = bucket_of(el, u);
                tbl_age[slot] = 0;
                queue_beat(KIND_STATUS, '0, 1'b1, '0, 1'b1);
            end
            CMD_UNREG: begin
                for (int i = 0; i < SLOTS; i++)
                    if (tbl_valid[i] && tbl_handle[i] == h &&
                        (slot < 0 || tbl_age[i] > tbl_age[slot])) slot = i;
                if (slot < 0) begin
                    queue_beat(KIND_STATUS, '0, 1'b0, '0, 1'b1);
                    return;
                end
                tbl_valid[slot] = 1'b0;
                for (int i = 0; i < SLOTS; i++)
                    if (tbl_valid[i] && tbl_age[i] > tbl_age[slot]) tbl_age[i]--;
                queue_beat(KIND_STATUS, '0, 1'b1, '0, 1'b1);
            end
            CMD_TICK: begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (!tbl_valid[i] || tbl_deadline[i] > now) continue;
                    j = due.size();
                    while (j > 0 && fires_first(i, due[j-1])) j--;
                    due.insert(j, i);
                end
                foreach (due[k]) begin
                    queue_beat(KIND_FIRED, tbl_handle[due[k]], 1'b0, '0, 1'b0);
                    tbl_deadline[due[k]] = now + tbl_period[due[k]];
                end
                for (int i = 0; i < SLOTS; i++) begin
                    if (!tbl_valid[i]) continue;
                    if (!any || tbl_deadline[i] < best) best = tbl_deadline[i];
                    any = 1'b1;
                end
                queue_beat(KIND_SLEEP, '0, 1'b0, any ? best - now : ALL_ONES, 1'b1);
            end
            default: queue_beat(KIND_STATUS, '0, 1'b0, '0, 1'b1);
        endcase
    endfunction

    task automatic send_item(input logic [1:0] cmd, input logic [15:0] h,
                             input logic [31:0] el, input logic [1:0] u,
                             input logic [63:0] now);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_command <= cmd;
        i_handle <= h;
        i_elapse <= el;
        i_unit <= u;
        i_now <= now;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        predict_scheduler(cmd, h, el, u, now);
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        while (pending_beats.size() != 0) @(negedge i_clk);
        repeat (400) @(negedge i_clk);
    endtask

    task automatic tick_at(input logic [63:0] now);
        send_item(CMD_TICK, 16'($urandom), $urandom, 2'($urandom), now);
    endtask

    task automatic test_directed();
        clock_ns = '0;
        tick_at(64'd0);
        send_item(CMD_UNREG, 16'h0000, 32'd0, 2'd0, 64'd0);
        send_item(CMD_REG, 16'h0001, 32'd0, 2'd1, 64'd0);
        send_item(CMD_BAD, 16'hFFFF, 32'hFFFF_FFFF, 2'd3, ALL_ONES);
        send_item(CMD_REG, 16'h0000, 32'd5, 2'd0, 64'd0);
        send_item(CMD_REG, 16'hFFFF, 32'hFFFF_FFFF, 2'd3, ALL_ONES);
        send_item(CMD_REG, 16'h0007, 32'd1234567, 2'd1, 64'd10);
        send_item(CMD_REG, 16'h0008, 32'd5, 2'd0, 64'd0);
        send_item(CMD_REG, 16'h0009, 32'd999, 2'd2, 64'd3);
        tick_at(64'd5);
        tick_at(64'd5);
        tick_at(64'hFFFF_FFFF_FFFF_FFF0);
        send_item(CMD_UNREG, 16'h0008, 32'd0, 2'd0, 64'd0);
        send_item(CMD_UNREG, 16'h0008, 32'd0, 2'd0, 64'd0);
        send_item(CMD_UNREG, 16'h1234, 32'd0, 2'd0, 64'd0);
        for (int i = 0; i < 14; i++) send_item(CMD_REG, i[15:0], 32'd1, 2'd0, 64'd100);
        send_item(CMD_REG, 16'h00AA, 32'd1, 2'd0, 64'd100);
        tick_at(ALL_ONES);
        drain_results();
    endtask

    task automatic test_random_traffic(input int count);
        logic [1:0] cmd;
        logic [15:0] h;
        int r;
        int live;
        for (int n = 0; n < count; n++) begin
            live = 0;
            foreach (tbl_valid[i]) live += int'(tbl_valid[i]);
            r = $urandom_range(0, 99);
            h = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 7));
            if (r < 50) begin
                clock_ns += ($urandom_range(0, 3) == 0) ? 64'($urandom) : 64'($urandom_range(0, 3000));
                if ($urandom_range(0, 30) == 0) clock_ns = {$urandom, $urandom};
                tick_at(clock_ns);
            end else if (r < 75 - live) begin
                case ($urandom_range(0, 3))
                    0: send_item(CMD_REG, h, $urandom_range(0, 3000), 2'($urandom), clock_ns);
                    1: send_item(CMD_REG, h, $urandom, 2'd0, clock_ns);
                    2: send_item(CMD_REG, h, $urandom, 2'($urandom), clock_ns);
                    default: send_item(CMD_REG, h, $urandom_range(1, 9), 2'd1, clock_ns);
                endcase
            end else if (r < 97) begin
                send_item(CMD_UNREG, h, $urandom, 2'($urandom), {$urandom, $urandom});
            end else begin
                cmd = CMD_BAD;
                send_item(cmd, 16'($urandom), $urandom, 2'($urandom), {$urandom, $urandom});
            end
            if (n == count / 2) drain_results();
        end
        drain_results();
    endtask

    initial begin
        t_result want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready) begin
                if (pending_beats.size() == 0) begin
                    report("unexpected beat", 64'(o_kind), '0);
                end else begin
                    want = pending_beats.pop_front();
                    if (o_kind !== want.kind) report("kind", 64'(o_kind), 64'(want.kind));
                    if (o_fired_handle !== want.fired_handle)
                        report("fired_handle", 64'(o_fired_handle), 64'(want.fired_handle));
                    if (o_accepted !== want.accepted)
                        report("accepted", 64'(o_accepted), 64'(want.accepted));
                    if (o_wait_ns !== want.wait_ns) report("wait_ns", o_wait_ns, want.wait_ns);
                    if (o_last !== want.last) report("last", 64'(o_last), 64'(want.last));
                end
            end
        end
    end

    initial begin
        int hold;
        i_ready = 1'b0;
        hold = 0;
        forever begin
            @(negedge i_clk);
            if (o_valid && i_ready) begin
                hold = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 9);
            end
            if (hold > 0) begin
                i_ready <= 1'b0;
                hold--;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready) || !i_rst_n) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial begin
        fail_count = 0;
        for (int i = 0; i < SLOTS; i++) begin
            tbl_valid[i] = 1'b0; tbl_age[i] = 0;
        end
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_command = CMD_REG;
        i_handle = '0;
        i_elapse = '0;
        i_unit = '0;
        i_now = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_random_traffic(500);
        if (fail_count == 0) $display("ALL CHECKS PASSED");
        else $display("CHECKS FAILED");
        $finish;
    end
endmodule
